[rtl/core/segx_pkg.sv]
// Package for the segment intersection pipeline: widths, payload structs
// and divider stage type. No dependencies.
package segx_pkg;

    localparam int COORD_BITS = 16;
    localparam int DW  = COORD_BITS + 1;   // coordinate difference
    localparam int PW  = 2 * DW;           // cross product term
    localparam int NW  = PW + 1;           // den / num
    localparam int MW  = NW + DW;          // num times direction
    localparam int RW  = MW + 2;           // doubled plus den, signed
    localparam int QB  = COORD_BITS + 2;   // quotient bits kept
    localparam int AW  = RW + QB;          // divider working width
    localparam int RSW = QB + 2;           // crossing coordinate, signed

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } t_seg_in;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
    } t_seg_out;

    typedef struct packed {
        logic [AW-1:0] rem;
        logic [NW:0]   den2;
        logic [QB-1:0] q;
        logic          neg;
        logic          far;
    } t_div;

endpackage

[rtl/core/segment_intersection_top.sv]
// Top level of the segment intersection pipeline.
// Depends on segx_pkg.
//
// Fully pipelined: one segment pair is accepted every cycle, busy is always low.
// o_done is high for one cycle with each result; the divider has
// QB = COORD_BITS + 2 restoring stages, one quotient bit each.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
// The receiver cannot stall; results are shown for one cycle only.
module segment_intersection_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  segx_pkg::t_seg_in    i_item,
    output logic                 o_done,
    output segx_pkg::t_seg_out   o_res
);
    localparam int NS = 8 + segx_pkg::QB;
    localparam int W  = segx_pkg::COORD_BITS;
    localparam int DW = segx_pkg::DW;

    logic              r_vld [NS];
    segx_pkg::t_seg_in r_inp [NS];

    // stage 1: differences
    logic signed [DW-1:0] r_d1x, r_d1y, r_d2x, r_d2y, r_ex, r_ey;
    // stage 2: products
    logic signed [segx_pkg::PW-1:0] r_pa, r_pb, r_pc, r_pd;
    // stage 3: den made positive
    logic signed [segx_pkg::NW-1:0] r_den3, r_num3, n_den, n_num;
    // stage 4
    logic signed [segx_pkg::NW-1:0] r_den4;
    logic signed [segx_pkg::MW-1:0] r_nx, r_ny;
    logic signed [DW-1:0]           n_d1x, n_d1y;
    // stage 5
    logic signed [segx_pkg::RW-1:0] n_mx, n_my;
    logic [segx_pkg::RW-1:0]        r_magx, r_magy;
    logic                           r_negx, r_negy;
    logic [segx_pkg::NW:0]          r_den2;
    // divider lines
    segx_pkg::t_div r_dx [segx_pkg::QB+1];
    segx_pkg::t_div r_dy [segx_pkg::QB+1];
    segx_pkg::t_div n_dx [segx_pkg::QB+1];
    segx_pkg::t_div n_dy [segx_pkg::QB+1];
    // result stage
    logic signed [segx_pkg::RSW-1:0] r_cx, r_cy;
    logic                            r_far;

    assign busy = 1'b0;

    function automatic segx_pkg::t_div div_step(segx_pkg::t_div d, int k);
        logic [segx_pkg::AW-1:0] sub;
        segx_pkg::t_div          r;
        sub = segx_pkg::AW'(d.den2) << k;
        r   = d;
        if (d.rem >= sub) begin
            r.rem  = d.rem - sub;
            r.q[k] = 1'b1;
        end
        return r;
    endfunction

    function automatic segx_pkg::t_div div_init(logic [segx_pkg::RW-1:0] mag, logic neg,
                                               logic [segx_pkg::NW:0] den2);
        segx_pkg::t_div r;
        r.rem  = segx_pkg::AW'(mag);
        r.den2 = den2;
        r.q    = '0;
        r.neg  = neg;
        // zero den lands here too, so it never hits
        r.far  = (segx_pkg::AW'(mag) >= (segx_pkg::AW'(den2) << segx_pkg::QB));
        return r;
    endfunction

    function automatic logic signed [segx_pkg::RSW-1:0] axis_res(segx_pkg::t_div d,
                                                               logic signed [W-1:0] base);
        logic [segx_pkg::RSW-1:0] qa;
        logic signed [segx_pkg::RSW-1:0] off;
        qa  = segx_pkg::RSW'(d.q) + segx_pkg::RSW'(d.neg && (d.rem != '0));
        off = d.neg ? -$signed(qa) : $signed(qa);
        return segx_pkg::RSW'(base) + off;
    endfunction

    function automatic logic in_box(logic signed [segx_pkg::RSW-1:0] v,
                                    logic signed [W-1:0] a, logic signed [W-1:0] b);
        logic signed [segx_pkg::RSW-1:0] lo, hi;
        lo = (a < b) ? segx_pkg::RSW'(a) : segx_pkg::RSW'(b);
        hi = (a < b) ? segx_pkg::RSW'(b) : segx_pkg::RSW'(a);
        return (v >= lo) && (v <= hi);
    endfunction

    always_comb begin
        n_den = segx_pkg::NW'(r_pa) - segx_pkg::NW'(r_pb);
        n_num = segx_pkg::NW'(r_pc) - segx_pkg::NW'(r_pd);
        if (n_den < 0) begin
            n_den = -n_den;
            n_num = -n_num;
        end
        n_d1x = DW'(r_inp[3].first_end_x) - DW'(r_inp[3].first_start_x);
        n_d1y = DW'(r_inp[3].first_end_y) - DW'(r_inp[3].first_start_y);
        n_mx  = (segx_pkg::RW'(r_nx) <<< 1) + segx_pkg::RW'(r_den4);
        n_my  = (segx_pkg::RW'(r_ny) <<< 1) + segx_pkg::RW'(r_den4);
        n_dx[0] = div_init(r_magx, r_negx, r_den2);
        n_dy[0] = div_init(r_magy, r_negy, r_den2);
        for (int j = 0; j < segx_pkg::QB; j++) begin
            n_dx[j+1] = div_step(r_dx[j], segx_pkg::QB - 1 - j);
            n_dy[j+1] = div_step(r_dy[j], segx_pkg::QB - 1 - j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) r_vld[i] <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_vld[0] <= start;
            for (int i = 1; i < NS; i++) r_vld[i] <= r_vld[i-1];
            o_done <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_inp[0] <= i_item;
        for (int i = 1; i < NS; i++) r_inp[i] <= r_inp[i-1];

        r_d1x <= DW'(r_inp[0].first_end_x) - DW'(r_inp[0].first_start_x);
        r_d1y <= DW'(r_inp[0].first_end_y) - DW'(r_inp[0].first_start_y);
        r_d2x <= DW'(r_inp[0].second_end_x) - DW'(r_inp[0].second_start_x);
        r_d2y <= DW'(r_inp[0].second_end_y) - DW'(r_inp[0].second_start_y);
        r_ex  <= DW'(r_inp[0].second_start_x) - DW'(r_inp[0].first_start_x);
        r_ey  <= DW'(r_inp[0].second_start_y) - DW'(r_inp[0].first_start_y);

        r_pa <= r_d1x * r_d2y;
        r_pb <= r_d1y * r_d2x;
        r_pc <= r_ex * r_d2y;
        r_pd <= r_ey * r_d2x;

        r_den3 <= n_den;
        r_num3 <= n_num;

        r_den4 <= r_den3;
        r_nx   <= r_num3 * n_d1x;
        r_ny   <= r_num3 * n_d1y;

        r_negx <= n_mx[segx_pkg::RW-1];
        r_negy <= n_my[segx_pkg::RW-1];
        r_magx <= n_mx[segx_pkg::RW-1] ? segx_pkg::RW'(-n_mx) : segx_pkg::RW'(n_mx);
        r_magy <= n_my[segx_pkg::RW-1] ? segx_pkg::RW'(-n_my) : segx_pkg::RW'(n_my);
        r_den2 <= {r_den4, 1'b0};

        for (int j = 0; j <= segx_pkg::QB; j++) begin
            r_dx[j] <= n_dx[j];
            r_dy[j] <= n_dy[j];
        end

        r_cx  <= axis_res(r_dx[segx_pkg::QB], r_inp[NS-2].first_start_x);
        r_cy  <= axis_res(r_dy[segx_pkg::QB], r_inp[NS-2].first_start_y);
        r_far <= r_dx[segx_pkg::QB].far || r_dy[segx_pkg::QB].far;

        if (!r_far
            && in_box(r_cx, r_inp[NS-1].first_start_x, r_inp[NS-1].first_end_x)
            && in_box(r_cx, r_inp[NS-1].second_start_x, r_inp[NS-1].second_end_x)
            && in_box(r_cy, r_inp[NS-1].first_start_y, r_inp[NS-1].first_end_y)
            && in_box(r_cy, r_inp[NS-1].second_start_y, r_inp[NS-1].second_end_y)) begin
            o_res.hit     <= 1'b1;
            o_res.cross_x <= r_cx[W-1:0];
            o_res.cross_y <= r_cy[W-1:0];
        end else begin
            o_res.hit     <= 1'b0;
            o_res.cross_x <= '0;
            o_res.cross_y <= '0;
        end
    end

endmodule
